@@ rtl/pbse_pkg.sv @@
// ----------------------------------------------------------------------------
// pbse_pkg
// Shared constants, codes and types of the piecewise Bezier surface evaluator.
// ----------------------------------------------------------------------------
package pbse_pkg;

   localparam int SEGMENTS          = 4;
   localparam int TERMS_PER_SEGMENT = 16;
   localparam int STORE_DEPTH       = SEGMENTS * TERMS_PER_SEGMENT;
   localparam int ADDR_W            = $clog2(STORE_DEPTH);
   localparam int SEG_W             = (SEGMENTS > 1) ? $clog2(SEGMENTS) : 1;
   localparam int TERM_W            = $clog2(TERMS_PER_SEGMENT);

   localparam int REQ_DATA_W = 96;
   localparam int RSP_DATA_W = 56;
   localparam int CSR_IDX_W  = 2;

   // request kinds
   localparam logic REQ_WRITE = 1'b0;
   localparam logic REQ_EVAL  = 1'b1;

   // configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_DELIM_FIRST  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DELIM_SECOND = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_DELIM_THIRD  = 2'd2;

   localparam logic signed [15:0] DELIM_FIRST_RST  = 16'sd1024;
   localparam logic signed [15:0] DELIM_SECOND_RST = 16'sd2048;
   localparam logic signed [15:0] DELIM_THIRD_RST  = 16'sd3072;

   // evaluation modes
   localparam logic [2:0] MODE_VALUE = 3'd0;
   localparam logic [2:0] MODE_DP    = 3'd1;
   localparam logic [2:0] MODE_DS    = 3'd2;
   localparam logic [2:0] MODE_DI    = 3'd3;
   localparam logic [2:0] MODE_DPP   = 3'd4;
   localparam logic [2:0] MODE_DPDS  = 3'd5;
   localparam logic [2:0] MODE_DPDI  = 3'd6;
   localparam logic [2:0] MODE_UNDEF = 3'd7;

   // basis setup steps
   localparam logic [3:0] BS_QQ   = 4'd0;
   localparam logic [3:0] BS_QP   = 4'd1;
   localparam logic [3:0] BS_PP   = 4'd2;
   localparam logic [3:0] BS_QQQ  = 4'd3;
   localparam logic [3:0] BS_QQP  = 4'd4;
   localparam logic [3:0] BS_QPP  = 4'd5;
   localparam logic [3:0] BS_PPP  = 4'd6;
   localparam logic [3:0] BS_DONE = 4'd7;

   // per-term steps
   localparam logic [3:0] TS_P_LO  = 4'd0;
   localparam logic [3:0] TS_P_HI  = 4'd1;
   localparam logic [3:0] TS_A_RND = 4'd2;
   localparam logic [3:0] TS_A_LO  = 4'd3;
   localparam logic [3:0] TS_A_HI  = 4'd4;
   localparam logic [3:0] TS_T_RND = 4'd5;
   localparam logic [3:0] TS_T_LO  = 4'd6;
   localparam logic [3:0] TS_T_HI  = 4'd7;
   localparam logic [3:0] TS_ACC   = 4'd8;

   localparam logic [TERM_W-1:0] TERM_LAST = TERM_W'(TERMS_PER_SEGMENT - 1);

   localparam logic signed [47:0] RESULT_MAX = 48'sh7FFF_FFFF_FFFF;
   localparam logic signed [47:0] RESULT_MIN = 48'sh8000_0000_0000;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_BASIS,
      ST_TERM,
      ST_FINISH
   } pbse_state_type;

   typedef struct packed {
      logic              load;
      logic              coef_write;
      logic              basis_en;
      logic              term_en;
      logic [3:0]        step;
      logic [TERM_W-1:0] term_idx;
      logic              finish;
   } pbse_cmd_type;

   typedef struct packed {
      logic rsp_full;
   } pbse_status_type;

endpackage

@@ rtl/pbse_ctrl.sv @@
// ----------------------------------------------------------------------------
// pbse_ctrl
// Sequencer: basis setup, sixteen term passes and result hand-off.
// ----------------------------------------------------------------------------
module pbse_ctrl (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   input  logic                      req_type,
   input  logic [2:0]                eval_mode,
   input  pbse_pkg::pbse_status_type status,
   output logic                      req_tready,
   output pbse_pkg::pbse_cmd_type    cmd
);

   pbse_pkg::pbse_state_type state_ff, state_in;
   logic [3:0]                      step_ff, step_in;
   logic [pbse_pkg::TERM_W-1:0]     k_ff, k_in;
   logic                            eval_go;

   assign eval_go = (state_ff == pbse_pkg::ST_IDLE) && req_tvalid &&
                    (req_type == pbse_pkg::REQ_EVAL) && (eval_mode != pbse_pkg::MODE_UNDEF);

   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      k_in     = k_ff;
      case (state_ff)
         pbse_pkg::ST_IDLE: begin
            if (eval_go) begin
               state_in = pbse_pkg::ST_BASIS;
               step_in  = pbse_pkg::BS_QQ;
            end
         end
         pbse_pkg::ST_BASIS: begin
            if (step_ff == pbse_pkg::BS_DONE) begin
               state_in = pbse_pkg::ST_TERM;
               step_in  = pbse_pkg::TS_P_LO;
               k_in     = '0;
            end else begin
               step_in = step_ff + 4'd1;
            end
         end
         pbse_pkg::ST_TERM: begin
            if (step_ff == pbse_pkg::TS_ACC) begin
               step_in = pbse_pkg::TS_P_LO;
               if (k_ff == pbse_pkg::TERM_LAST) begin
                  state_in = pbse_pkg::ST_FINISH;
               end else begin
                  k_in = k_ff + 1'b1;
               end
            end else begin
               step_in = step_ff + 4'd1;
            end
         end
         pbse_pkg::ST_FINISH: begin
            // hold until the output register can take the result
            if (!status.rsp_full) begin
               state_in = pbse_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = pbse_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      req_tready     = (state_ff == pbse_pkg::ST_IDLE);
      cmd.load       = eval_go;
      cmd.coef_write = (state_ff == pbse_pkg::ST_IDLE) && req_tvalid &&
                       (req_type == pbse_pkg::REQ_WRITE);
      cmd.basis_en   = (state_ff == pbse_pkg::ST_BASIS);
      cmd.term_en    = (state_ff == pbse_pkg::ST_TERM);
      cmd.step       = step_ff;
      cmd.term_idx   = k_ff;
      cmd.finish     = (state_ff == pbse_pkg::ST_FINISH) && !status.rsp_full;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= pbse_pkg::ST_IDLE;
         step_ff  <= '0;
         k_ff     <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
         k_ff     <= k_in;
      end
   end

endmodule

@@ rtl/pbse_datapath.sv @@
// ----------------------------------------------------------------------------
// pbse_datapath
// Coefficient memory, delimiters, shared 33x33 multiplier, accumulator and
// output register.
// ----------------------------------------------------------------------------
module pbse_datapath (
   input  logic                                clock,
   input  logic                                reset,
   input  pbse_pkg::pbse_cmd_type              cmd,
   output pbse_pkg::pbse_status_type           status,
   input  logic [5:0]                          coeff_index,
   input  logic signed [31:0]                  coeff_value,
   input  logic signed [15:0]                  phase_in,
   input  logic signed [15:0]                  step_length_in,
   input  logic signed [15:0]                  incline_in,
   input  logic [2:0]                          eval_mode,
   input  logic                                csr_valid,
   input  logic [pbse_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [15:0]                         csr_data,
   input  logic                                rsp_tready,
   output logic                                rsp_tvalid,
   output logic signed [47:0]                  result_value,
   output logic [2:0]                          result_mode,
   output logic [1:0]                          result_segment
);

   // configuration
   logic signed [15:0] delim_first_ff, delim_first_in;
   logic signed [15:0] delim_second_ff, delim_second_in;
   logic signed [15:0] delim_third_ff, delim_third_in;

   // captured request
   logic signed [15:0]          phase_ff, phase_nx_in;
   logic signed [15:0]          slen_ff, slen_in;
   logic signed [15:0]          incl_ff, incl_in;
   logic [2:0]                  mode_ff, mode_in;
   logic [pbse_pkg::SEG_W-1:0]  seg_ff, seg_in;

   // arithmetic state
   logic signed [32:0] qq_ff, qq_in, qp_ff, qp_in, pp_ff, pp_in;
   logic signed [47:0] pt_ff [4];
   logic signed [47:0] pt_in [4];
   logic signed [65:0] prod_ff, prod_in;
   logic signed [65:0] tmp_ff, tmp_in;
   logic signed [39:0] a_ff, a_in;
   logic signed [43:0] t_ff, t_in;
   logic signed [79:0] acc_ff, acc_in;

   // memory
   logic signed [31:0]               coef_mem [pbse_pkg::STORE_DEPTH];
   logic signed [31:0]               coef_rd_ff;
   logic [pbse_pkg::ADDR_W-1:0]      wr_addr, rd_addr;

   // output register
   logic               rsp_valid_ff, rsp_valid_in;
   logic signed [47:0] res_value_ff, res_value_in;
   logic [2:0]         res_mode_ff, res_mode_in;
   logic [1:0]         res_seg_ff, res_seg_in;

   // combinational helpers
   logic [1:0]         dp;
   logic               ds, di;
   logic signed [16:0] p17, q17, s17, i17, ws, wi;
   logic signed [47:0] p_sel;
   logic signed [32:0] mul_a, mul_b;
   logic signed [67:0] tmp_ext, prod_ext, rnd_bias, rnd_sum;
   logic signed [79:0] prod80, fin_sum;
   logic signed [47:0] qq48, qp48, pp48, q48, p48, prod48;
   logic signed [15:0] pc;
   logic [1:0]         seg_raw;

   // ---------------- configuration ----------------
   always_comb begin
      delim_first_in  = delim_first_ff;
      delim_second_in = delim_second_ff;
      delim_third_in  = delim_third_ff;
      if (csr_valid) begin
         case (csr_index)
            pbse_pkg::CSR_DELIM_FIRST:  delim_first_in  = csr_data;
            pbse_pkg::CSR_DELIM_SECOND: delim_second_in = csr_data;
            pbse_pkg::CSR_DELIM_THIRD:  delim_third_in  = csr_data;
            default: ;
         endcase
      end
   end

   // ---------------- segment choice on the clamped phase ----------------
   always_comb begin
      if (phase_in < 16'sd0) begin
         pc = 16'sd0;
      end else if (phase_in > 16'sd4096) begin
         pc = 16'sd4096;
      end else begin
         pc = phase_in;
      end
      if (pc <= delim_first_ff) begin
         seg_raw = 2'd0;
      end else if (pc <= delim_second_ff) begin
         seg_raw = 2'd1;
      end else if (pc <= delim_third_ff) begin
         seg_raw = 2'd2;
      end else begin
         seg_raw = 2'd3;
      end
      if (int'(seg_raw) > pbse_pkg::SEGMENTS - 1) begin
         seg_in = pbse_pkg::SEG_W'(pbse_pkg::SEGMENTS - 1);
      end else begin
         seg_in = pbse_pkg::SEG_W'(seg_raw);
      end
   end

   always_comb begin
      phase_nx_in = phase_ff;
      slen_in     = slen_ff;
      incl_in     = incl_ff;
      mode_in     = mode_ff;
      if (cmd.load) begin
         phase_nx_in = phase_in;
         slen_in     = step_length_in;
         incl_in     = incline_in;
         mode_in     = eval_mode;
      end
   end

   // ---------------- derivative orders of the mode ----------------
   always_comb begin
      dp = 2'd0;
      ds = 1'b0;
      di = 1'b0;
      case (mode_ff)
         pbse_pkg::MODE_DP:   dp = 2'd1;
         pbse_pkg::MODE_DS:   ds = 1'b1;
         pbse_pkg::MODE_DI:   di = 1'b1;
         pbse_pkg::MODE_DPP:  dp = 2'd2;
         pbse_pkg::MODE_DPDS: begin
            dp = 2'd1;
            ds = 1'b1;
         end
         pbse_pkg::MODE_DPDI: begin
            dp = 2'd1;
            di = 1'b1;
         end
         default: ;
      endcase
   end

   // ---------------- weights ----------------
   assign p17 = {phase_ff[15], phase_ff};
   assign q17 = 17'sd4096 - p17;
   assign s17 = {slen_ff[15], slen_ff};
   assign i17 = {incl_ff[15], incl_ff};

   always_comb begin
      if (ds) begin
         ws = cmd.term_idx[2] ? -17'sd4096 : 17'sd4096;
      end else begin
         ws = cmd.term_idx[2] ? (17'sd4096 - s17) : s17;
      end
      if (di) begin
         wi = cmd.term_idx[3] ? -17'sd4096 : 17'sd4096;
      end else begin
         wi = cmd.term_idx[3] ? (17'sd4096 - i17) : i17;
      end
   end

   assign p_sel = pt_ff[cmd.term_idx[1:0]];

   // ---------------- shared multiplier ----------------
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      if (cmd.basis_en) begin
         case (cmd.step)
            pbse_pkg::BS_QQ: begin
               mul_a = {{16{q17[16]}}, q17};
               mul_b = {{16{q17[16]}}, q17};
            end
            pbse_pkg::BS_QP: begin
               mul_a = {{16{q17[16]}}, q17};
               mul_b = {{16{p17[16]}}, p17};
            end
            pbse_pkg::BS_PP: begin
               mul_a = {{16{p17[16]}}, p17};
               mul_b = {{16{p17[16]}}, p17};
            end
            pbse_pkg::BS_QQQ: begin
               mul_a = qq_ff;
               mul_b = {{16{q17[16]}}, q17};
            end
            pbse_pkg::BS_QQP: begin
               mul_a = qq_ff;
               mul_b = {{16{p17[16]}}, p17};
            end
            pbse_pkg::BS_QPP: begin
               mul_a = pp_ff;
               mul_b = {{16{q17[16]}}, q17};
            end
            pbse_pkg::BS_PPP: begin
               mul_a = pp_ff;
               mul_b = {{16{p17[16]}}, p17};
            end
            default: ;
         endcase
      end else if (cmd.term_en) begin
         case (cmd.step)
            pbse_pkg::TS_P_LO: begin
               mul_a = {1'b0, p_sel[31:0]};
               mul_b = {{16{ws[16]}}, ws};
            end
            pbse_pkg::TS_P_HI: begin
               mul_a = {{17{p_sel[47]}}, p_sel[47:32]};
               mul_b = {{16{ws[16]}}, ws};
            end
            pbse_pkg::TS_A_LO: begin
               mul_a = {1'b0, a_ff[31:0]};
               mul_b = {{16{wi[16]}}, wi};
            end
            pbse_pkg::TS_A_HI: begin
               mul_a = {{25{a_ff[39]}}, a_ff[39:32]};
               mul_b = {{16{wi[16]}}, wi};
            end
            pbse_pkg::TS_T_LO: begin
               mul_a = {1'b0, t_ff[31:0]};
               mul_b = {coef_rd_ff[31], coef_rd_ff};
            end
            pbse_pkg::TS_T_HI: begin
               mul_a = {{21{t_ff[43]}}, t_ff[43:32]};
               mul_b = {coef_rd_ff[31], coef_rd_ff};
            end
            default: ;
         endcase
      end
   end

   assign prod_in = mul_a * mul_b;

   // ---------------- basis write-back ----------------
   assign qq48   = {{15{qq_ff[32]}}, qq_ff};
   assign qp48   = {{15{qp_ff[32]}}, qp_ff};
   assign pp48   = {{15{pp_ff[32]}}, pp_ff};
   assign q48    = {{31{q17[16]}}, q17};
   assign p48    = {{31{p17[16]}}, p17};
   assign prod48 = prod_ff[47:0];

   always_comb begin
      qq_in = qq_ff;
      qp_in = qp_ff;
      pp_in = pp_ff;
      for (int j = 0; j < 4; j++) begin
         pt_in[j] = pt_ff[j];
      end
      if (cmd.basis_en) begin
         case (cmd.step)
            pbse_pkg::BS_QP:   qq_in = prod_ff[32:0];
            pbse_pkg::BS_PP:   qp_in = prod_ff[32:0];
            pbse_pkg::BS_QQQ:  pp_in = prod_ff[32:0];
            pbse_pkg::BS_QQP:  pt_in[0] = prod48;
            pbse_pkg::BS_QPP:  pt_in[1] = prod48 * 48'sd3;
            pbse_pkg::BS_PPP:  pt_in[2] = prod48 * 48'sd3;
            pbse_pkg::BS_DONE: begin
               case (dp)
                  2'd0: pt_in[3] = prod48;
                  2'd1: begin
                     pt_in[0] = (48'sd0 - qq48 * 48'sd3) <<< 12;
                     pt_in[1] = (qq48 * 48'sd3 - qp48 * 48'sd6) <<< 12;
                     pt_in[2] = (qp48 * 48'sd6 - pp48 * 48'sd3) <<< 12;
                     pt_in[3] = (pp48 * 48'sd3) <<< 12;
                  end
                  default: begin
                     pt_in[0] = (q48 * 48'sd6) <<< 24;
                     pt_in[1] = (p48 * 48'sd6 - q48 * 48'sd12) <<< 24;
                     pt_in[2] = (q48 * 48'sd6 - p48 * 48'sd12) <<< 24;
                     pt_in[3] = (p48 * 48'sd6) <<< 24;
                  end
               endcase
            end
            default: ;
         endcase
      end
   end

   // ---------------- term write-back ----------------
   assign tmp_ext  = {{2{tmp_ff[65]}}, tmp_ff};
   assign prod_ext = {{2{prod_ff[65]}}, prod_ff};
   assign rnd_bias = (cmd.step == pbse_pkg::TS_A_RND) ? 68'sd8388608 : 68'sd2048;
   // join low and high partial products, round half up
   assign rnd_sum  = tmp_ext + (prod_ext <<< 32) + rnd_bias;
   assign prod80   = {{14{prod_ff[65]}}, prod_ff};

   always_comb begin
      tmp_in = tmp_ff;
      a_in   = a_ff;
      t_in   = t_ff;
      acc_in = acc_ff;
      if (cmd.load) begin
         acc_in = '0;
      end else if (cmd.term_en) begin
         case (cmd.step)
            pbse_pkg::TS_P_HI:  tmp_in = prod_ff;
            pbse_pkg::TS_A_RND: a_in   = rnd_sum[63:24];
            pbse_pkg::TS_A_HI:  tmp_in = prod_ff;
            pbse_pkg::TS_T_RND: t_in   = rnd_sum[55:12];
            pbse_pkg::TS_T_HI:  acc_in = acc_ff + prod80;
            pbse_pkg::TS_ACC:   acc_in = acc_ff + (prod80 <<< 32);
            default: ;
         endcase
      end
   end

   // ---------------- final rounding and saturation ----------------
   assign fin_sum = acc_ff + 80'sd8388608;

   always_comb begin
      res_value_in = res_value_ff;
      res_mode_in  = res_mode_ff;
      res_seg_in   = res_seg_ff;
      rsp_valid_in = rsp_valid_ff;
      if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (cmd.finish) begin
         rsp_valid_in = 1'b1;
         res_mode_in  = mode_ff;
         res_seg_in   = 2'(seg_ff);
         if (!fin_sum[79] && (|fin_sum[78:71])) begin
            res_value_in = pbse_pkg::RESULT_MAX;
         end else if (fin_sum[79] && !(&fin_sum[78:71])) begin
            res_value_in = pbse_pkg::RESULT_MIN;
         end else begin
            res_value_in = fin_sum[71:24];
         end
      end
   end

   assign status.rsp_full = rsp_valid_ff && !rsp_tready;
   assign rsp_tvalid      = rsp_valid_ff;
   assign result_value    = res_value_ff;
   assign result_mode     = res_mode_ff;
   assign result_segment  = res_seg_ff;

   // ---------------- coefficient memory ----------------
   assign wr_addr = pbse_pkg::ADDR_W'(coeff_index);
   assign rd_addr = pbse_pkg::ADDR_W'({seg_ff, cmd.term_idx});

   always_ff @(posedge clock) begin
      if (cmd.coef_write && (int'(coeff_index) < pbse_pkg::STORE_DEPTH)) begin
         coef_mem[wr_addr] <= coeff_value;
      end
      coef_rd_ff <= coef_mem[rd_addr];
   end

   // ---------------- registers ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         delim_first_ff  <= pbse_pkg::DELIM_FIRST_RST;
         delim_second_ff <= pbse_pkg::DELIM_SECOND_RST;
         delim_third_ff  <= pbse_pkg::DELIM_THIRD_RST;
         rsp_valid_ff    <= 1'b0;
      end else begin
         delim_first_ff  <= delim_first_in;
         delim_second_ff <= delim_second_in;
         delim_third_ff  <= delim_third_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      phase_ff     <= phase_nx_in;
      slen_ff      <= slen_in;
      incl_ff      <= incl_in;
      mode_ff      <= mode_in;
      if (cmd.load) begin
         seg_ff <= seg_in;
      end
      qq_ff        <= qq_in;
      qp_ff        <= qp_in;
      pp_ff        <= pp_in;
      for (int j = 0; j < 4; j++) begin
         pt_ff[j] <= pt_in[j];
      end
      prod_ff      <= prod_in;
      tmp_ff       <= tmp_in;
      a_ff         <= a_in;
      t_ff         <= t_in;
      acc_ff       <= acc_in;
      res_value_ff <= res_value_in;
      res_mode_ff  <= res_mode_in;
      res_seg_ff   <= res_seg_in;
   end

endmodule

@@ rtl/piecewise_bezier_surface_eval.sv @@
// An evaluate item runs basis setup, sixteen term passes and a final rounding
// step, which waits while the output register is still full.
// The single shared 33x33 multiplier forms every partial product, so no new
// write or evaluate item is accepted until the sequencer is idle again.
// Reset (synchronous, active high) idles the sequencer, empties the output
// register and restores the delimiters; coefficient memory is not cleared.
// ----------------------------------------------------------------------------
// piecewise_bezier_surface_eval
// Piecewise cubic Bernstein tensor evaluator with 64 stored coefficients.
// ----------------------------------------------------------------------------
module piecewise_bezier_surface_eval (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   // coeff_index[5:0], coeff_value[37:6], phase_in[53:38], step_length_in[69:54],
   // incline_in[85:70], eval_mode[88:86], zero fill above
   input  logic [pbse_pkg::REQ_DATA_W-1:0]      req_tdata,
   // req_type[0]
   input  logic                                 req_tuser,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // result_value[47:0], result_mode[50:48], result_segment[52:51], zero fill above
   output logic [pbse_pkg::RSP_DATA_W-1:0]      rsp_tdata,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [pbse_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [15:0]                          csr_data
);

   pbse_pkg::pbse_cmd_type    cmd;
   pbse_pkg::pbse_status_type status;
   logic signed [47:0]        result_value;
   logic [2:0]                result_mode;
   logic [1:0]                result_segment;

   assign csr_ready = 1'b1;

   pbse_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_type   (req_tuser),
      .eval_mode  (req_tdata[88:86]),
      .status     (status),
      .req_tready (req_tready),
      .cmd        (cmd)
   );

   pbse_datapath u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .status         (status),
      .coeff_index    (req_tdata[5:0]),
      .coeff_value    (req_tdata[37:6]),
      .phase_in       (req_tdata[53:38]),
      .step_length_in (req_tdata[69:54]),
      .incline_in     (req_tdata[85:70]),
      .eval_mode      (req_tdata[88:86]),
      .csr_valid      (csr_valid),
      .csr_index      (csr_index),
      .csr_data       (csr_data),
      .rsp_tready     (rsp_tready),
      .rsp_tvalid     (rsp_tvalid),
      .result_value   (result_value),
      .result_mode    (result_mode),
      .result_segment (result_segment)
   );

   assign rsp_tdata = {3'b000, result_segment, result_mode, result_value};

endmodule

@@ test/tb_piecewise_bezier_surface_eval.sv @@
// ----------------------------------------------------------------------------
// tb_piecewise_bezier_surface_eval
// Loads the coefficient store and sweeps the delimiter settings. Runs directed
// and random write and evaluate items through the block, with random idle
// cycles and output stalls. Each result is checked against a bit-exact predictor.
// ----------------------------------------------------------------------------
module tb_piecewise_bezier_surface_eval;

   typedef logic signed [127:0] wide_type;

   typedef struct {
      logic signed [47:0] value;
      logic [2:0]         mode;
      logic [1:0]         segment;
   } surface_result_type;

   localparam int CYCLE_LIMIT  = 2000000;
   localparam int DRAIN_CYCLES = 200;

   logic                            clock = 1'b0;
   logic                            reset = 1'b1;
   logic                            req_tvalid = 1'b0;
   logic                            req_tready;
   logic [pbse_pkg::REQ_DATA_W-1:0] req_tdata = '0;
   logic                            req_tuser = 1'b0;
   logic                            rsp_tvalid;
   logic                            rsp_tready = 1'b0;
   logic [pbse_pkg::RSP_DATA_W-1:0] rsp_tdata;
   logic                            csr_valid = 1'b0;
   logic                            csr_ready;
   logic [pbse_pkg::CSR_IDX_W-1:0]  csr_index = '0;
   logic [15:0]                     csr_data = '0;

   logic signed [31:0] coeff_mirror[pbse_pkg::STORE_DEPTH];
   logic signed [15:0] delim_mirror[3];
   surface_result_type pending_results[$];
   int                 errors = 0;
   int                 cycles = 0;
   int                 rsp_stall = 0;
   bit                 no_gaps = 0;

   piecewise_bezier_surface_eval uut (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("piecewise_bezier_surface_eval test failed");
         $finish;
      end
   end

   task automatic report(input string msg);
      $display("ERROR at cycle %0d: %s", cycles, msg);
      errors++;
   endtask

   // Bernstein term of derivative order d, scaled to Q36
   function automatic longint bern_term(longint p, int d, int k);
      longint q;
      longint v;
      q = 4096 - p;
      if (d == 0) begin
         case (k)
            0: v = q * q * q;
            1: v = 3 * q * q * p;
            2: v = 3 * q * p * p;
            default: v = p * p * p;
         endcase
         return v;
      end
      if (d == 1) begin
         case (k)
            0: v = -3 * q * q;
            1: v = 3 * q * q - 6 * q * p;
            2: v = 6 * q * p - 3 * p * p;
            default: v = 3 * p * p;
         endcase
         return v * 4096;
      end
      case (k)
         0: v = 6 * q;
         1: v = -2 * (6 * q) + 6 * p;
         2: v = 6 * q - 2 * (6 * p);
         default: v = 6 * p;
      endcase
      return v * 4096 * 4096;
   endfunction

   function automatic longint lin_term(longint x, int d, int k);
      if (d == 0) return (k == 0) ? x : 4096 - x;
      return (k == 0) ? 4096 : -4096;
   endfunction

   function automatic wide_type round_down(wide_type x, int n);
      return (x + (wide_type'(1) <<< (n - 1))) >>> n;
   endfunction

   function automatic surface_result_type predict_surface(logic signed [15:0] phase,
         logic signed [15:0] step_len, logic signed [15:0] incline, logic [2:0] mode);
      surface_result_type r;
      int       dp, ds, di, seg, k;
      longint   pc;
      wide_type a, t, acc, top;
      dp = (mode == pbse_pkg::MODE_DP || mode == pbse_pkg::MODE_DPDS ||
            mode == pbse_pkg::MODE_DPDI) ? 1 :
           (mode == pbse_pkg::MODE_DPP) ? 2 : 0;
      ds = (mode == pbse_pkg::MODE_DS || mode == pbse_pkg::MODE_DPDS) ? 1 : 0;
      di = (mode == pbse_pkg::MODE_DI || mode == pbse_pkg::MODE_DPDI) ? 1 : 0;
      pc = (phase < 0) ? 0 : (phase > 4096 ? 4096 : phase);
      if (pc <= delim_mirror[0]) seg = 0;
      else if (pc <= delim_mirror[1]) seg = 1;
      else if (pc <= delim_mirror[2]) seg = 2;
      else seg = 3;
      if (seg > pbse_pkg::SEGMENTS - 1) seg = pbse_pkg::SEGMENTS - 1;
      acc = 0;
      for (k = 0; k < 16; k++) begin
         a = round_down(wide_type'(bern_term(phase, dp, k % 4)) *
                        wide_type'(lin_term(step_len, ds, (k / 4) % 2)), 24);
         t = round_down(a * wide_type'(lin_term(incline, di, k / 8)), 12);
         acc += t * wide_type'(coeff_mirror[(seg * pbse_pkg::TERMS_PER_SEGMENT + k) %
                                            pbse_pkg::STORE_DEPTH]);
      end
      top = (acc + (wide_type'(1) <<< 23)) >>> 24;
      if (top > wide_type'(pbse_pkg::RESULT_MAX)) r.value = pbse_pkg::RESULT_MAX;
      else if (top < wide_type'(pbse_pkg::RESULT_MIN)) r.value = pbse_pkg::RESULT_MIN;
      else r.value = top[47:0];
      r.mode = mode;
      r.segment = seg[1:0];
      return r;
   endfunction

   // result side: random stall per item, sampled at the rising edge
   always @(negedge clock) begin
      if (rsp_stall > 0) begin
         rsp_stall--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      surface_result_type exp_r;
      if (!reset && rsp_tvalid && rsp_tready) begin
         rsp_stall = no_gaps ? 0 : $urandom_range(0, 6);
         if (pending_results.size() == 0) begin
            report($sformatf("unexpected result %h", rsp_tdata));
         end else begin
            exp_r = pending_results.pop_front();
            if (rsp_tdata[47:0] !== exp_r.value)
               report($sformatf("value %h, expected %h", rsp_tdata[47:0], exp_r.value));
            if (rsp_tdata[50:48] !== exp_r.mode)
               report($sformatf("mode %0d, expected %0d", rsp_tdata[50:48], exp_r.mode));
            if (rsp_tdata[52:51] !== exp_r.segment)
               report($sformatf("segment %0d, expected %0d", rsp_tdata[52:51],
                                exp_r.segment));
         end
      end
   end

   // drive one item; keep valid high through back-to-back items
   task automatic send_item(input logic kind, input logic [5:0] index,
         input logic signed [31:0] coeff, input logic signed [15:0] phase,
         input logic signed [15:0] step_len, input logic signed [15:0] incline,
         input logic [2:0] mode);
      int gap;
      gap = no_gaps ? 0 : $urandom_range(0, 6);
      @(negedge clock);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tuser  <= kind;
      req_tdata  <= {7'd0, mode, incline, step_len, phase, coeff, index};
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      if (kind == pbse_pkg::REQ_WRITE) begin
         coeff_mirror[index] = coeff;
      end else if (mode != pbse_pkg::MODE_UNDEF) begin
         pending_results.push_back(predict_surface(phase, step_len, incline, mode));
      end
   endtask

   task automatic write_coeff(input logic [5:0] index, input logic signed [31:0] coeff);
      send_item(pbse_pkg::REQ_WRITE, index, coeff, 16'sd0, 16'sd0, 16'sd0,
                pbse_pkg::MODE_VALUE);
   endtask

   task automatic evaluate(input logic signed [15:0] phase,
         input logic signed [15:0] step_len, input logic signed [15:0] incline,
         input logic [2:0] mode);
      send_item(pbse_pkg::REQ_EVAL, 6'($urandom), 32'($urandom), phase, step_len,
                incline, mode);
   endtask

   task automatic wait_idle();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_delimiter(input logic [pbse_pkg::CSR_IDX_W-1:0] idx,
         input logic signed [15:0] value);
      @(negedge clock);
      csr_index <= idx;
      csr_data  <= value;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      delim_mirror[idx] = value;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic set_delimiters(input logic signed [15:0] d0,
         input logic signed [15:0] d1, input logic signed [15:0] d2);
      wait_idle();
      write_delimiter(pbse_pkg::CSR_DELIM_FIRST, d0);
      write_delimiter(pbse_pkg::CSR_DELIM_SECOND, d1);
      write_delimiter(pbse_pkg::CSR_DELIM_THIRD, d2);
   endtask

   function automatic logic signed [15:0] rand_q12(input bit wide_range);
      if (wide_range) return 16'($urandom);
      return 16'($urandom_range(0, 4096));
   endfunction

   function automatic logic signed [31:0] rand_coeff();
      case ($urandom_range(0, 3))
         0: return 32'($urandom);
         1: return $urandom_range(0, 1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
         default: return 32'($signed($urandom_range(0, 262144)) - 131072);
      endcase
   endfunction

   task automatic test_load_store();
      int i;
      no_gaps = 1;
      for (i = 0; i < pbse_pkg::STORE_DEPTH; i++) write_coeff(6'(i), rand_coeff());
      no_gaps = 0;
   endtask

   task automatic test_directed();
      int m;
      // every mode at mid-range inputs, plus the undefined mode
      for (m = pbse_pkg::MODE_VALUE; m <= pbse_pkg::MODE_UNDEF; m++)
         evaluate(16'sd1500, 16'sd2048, 16'sd1000, 3'(m));
      // phase outside 0..1 and on the delimiters
      evaluate(16'sh8000, 16'sd0, 16'sd0, pbse_pkg::MODE_VALUE);
      evaluate(16'sd32767, 16'sd4096, 16'sd4096, pbse_pkg::MODE_DPP);
      evaluate(16'sd0, 16'sd0, 16'sd0, pbse_pkg::MODE_DP);
      evaluate(16'sd4096, 16'sd4096, 16'sd4096, pbse_pkg::MODE_VALUE);
      evaluate(16'sd1024, 16'sd1, 16'sd1, pbse_pkg::MODE_VALUE);
      evaluate(16'sd1025, 16'sd2, 16'sd3, pbse_pkg::MODE_DPDS);
      evaluate(16'sd3072, 16'sd5, 16'sd7, pbse_pkg::MODE_DPDI);
      // extreme step and incline; extreme coefficients
      evaluate(16'sh8000, 16'sh8000, 16'sh8000, pbse_pkg::MODE_VALUE);
      evaluate(16'sd32767, 16'sd32767, 16'sd32767, pbse_pkg::MODE_DPDS);
      write_coeff(6'd48, 32'sh7FFF_FFFF);
      write_coeff(6'd49, 32'sh8000_0000);
      evaluate(16'sh8000, 16'sd32767, 16'sh8000, pbse_pkg::MODE_VALUE);
      evaluate(16'sd32767, 16'sh8000, 16'sd32767, pbse_pkg::MODE_DI);
   endtask

   task automatic test_delimiters();
      int i;
      set_delimiters(16'sh8000, 16'sh8000, 16'sh8000);
      for (i = 0; i < 6; i++)
         evaluate(rand_q12(i > 3), 16'sd2048, 16'sd2048, pbse_pkg::MODE_VALUE);
      set_delimiters(16'sd32767, 16'sd32767, 16'sd32767);
      for (i = 0; i < 6; i++)
         evaluate(rand_q12(i > 3), 16'sd2048, 16'sd2048, pbse_pkg::MODE_DS);
      set_delimiters(16'sd3000, 16'sd2000, 16'sd1000);
      for (i = 0; i < 6; i++)
         evaluate(rand_q12(0), 16'sd1024, 16'sd512, pbse_pkg::MODE_DP);
   endtask

   task automatic test_random(input int count);
      int i;
      logic [2:0] mode;
      for (i = 0; i < count; i++) begin
         if (i % 50 == 0) no_gaps = ($urandom_range(0, 3) == 0);
         if (i % 250 == 249)
            set_delimiters(16'($urandom), 16'($urandom), 16'($urandom));
         if (i % 250 == 124) begin
            wait_idle();
            write_delimiter(pbse_pkg::CSR_IDX_W'($urandom_range(0, 2)), rand_q12(0));
         end
         if ($urandom_range(0, 1)) begin
            write_coeff(6'($urandom), rand_coeff());
         end else begin
            mode = ($urandom_range(0, 19) == 0) ? pbse_pkg::MODE_UNDEF :
                   3'($urandom_range(0, 6));
            evaluate(rand_q12($urandom_range(0, 4) == 0), rand_q12($urandom_range(0, 3) == 0),
                     rand_q12($urandom_range(0, 3) == 0), mode);
         end
      end
      no_gaps = 0;
   endtask

   initial begin
      delim_mirror[0] = pbse_pkg::DELIM_FIRST_RST;
      delim_mirror[1] = pbse_pkg::DELIM_SECOND_RST;
      delim_mirror[2] = pbse_pkg::DELIM_THIRD_RST;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      test_load_store();
      test_directed();
      test_delimiters();
      test_random(1000);
      wait_idle();
      if (errors == 0) begin
         $display("piecewise_bezier_surface_eval test passed");
      end else begin
         $display("piecewise_bezier_surface_eval test failed");
      end
      $finish;
   end

endmodule

@@ piecewise_bezier_surface_eval.f @@
rtl/pbse_pkg.sv
rtl/pbse_ctrl.sv
rtl/pbse_datapath.sv
rtl/piecewise_bezier_surface_eval.sv
test/tb_piecewise_bezier_surface_eval.sv
